// ===== src/integer_to_ascii_decimal_top_assert.svh =====
// Assertion macros for the integer to ASCII decimal converter.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef INTEGER_TO_ASCII_DECIMAL_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_DECIMAL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define I2AD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define I2AD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define I2AD_ASSERT_SAME(label, clk, rst, ante, cons)
`define I2AD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/i2ad_pkg.sv =====
// Shared types and constants of the integer to ASCII decimal converter.
// No dependencies; used by i2ad_digits and integer_to_ascii_decimal_top.
package i2ad_pkg;

   localparam int unsigned DIGIT_W = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SKIP    = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   // Operation requested of the digit register for the current cycle.
   typedef struct packed {
      logic load;
      logic dabble;
      logic drop;
   } digit_ctl_type;

endpackage

// ===== src/integer_to_ascii_decimal_top.sv =====
// Top level of the integer to ASCII decimal converter: sequencer, sign handling, output.
// Depends on i2ad_pkg, i2ad_digits and integer_to_ascii_decimal_top_assert.svh.
//
//   Channel   Ports                                   Handshake
//   -------   -------------------------------------   ------------------------------------
//   request   start, busy, req_value                  taken when start = 1 and busy = 0
//   response  rsp_strobe, rsp_char_code, rsp_last_char  one strobe per character, no stall
//   config    csr_write_enable, csr_write_data        written on every enabled edge
//
// A transaction is accepted at a clock edge with start high and busy low. For a negative
// value in signed mode the '-' character appears in the cycle right after acceptance.
// The shared add-3-and-shift unit then works through the input bits in turn, leading
// zero digits are dropped one per cycle, and the digits leave one per cycle. Busy stays
// high for the same length of time whatever the value.
// Reset is synchronous and active high; it idles the sequencer and sets signed mode.
// The receiver cannot stall: each character is valid for exactly its one strobe cycle.
`include "integer_to_ascii_decimal_top_assert.svh"

module integer_to_ascii_decimal_top
   import i2ad_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last_char,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   // Enough decimal digits for the largest unsigned value of VALUE_WIDTH bits.
   localparam int unsigned DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int unsigned CNT_W   = $clog2(VALUE_WIDTH);
   localparam int unsigned REM_W   = $clog2(DIGITS + 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [REM_W-1:0]       remain_ff, remain_in;
   logic                   signed_mode_ff, signed_mode_in;
   logic                   strobe_ff, strobe_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;

   logic [VALUE_WIDTH-1:0] value_bits;
   logic                   negative;
   logic [VALUE_WIDTH-1:0] magnitude;
   digit_ctl_type          digit_ctl;
   logic [DIGIT_W-1:0]     top_digit;

   // Only the low VALUE_WIDTH bits of the request take part. The two's complement
   // negation also covers the most negative value: its magnitude is the sign weight,
   // which fits as an unsigned VALUE_WIDTH-bit number.
   assign value_bits = req_value[VALUE_WIDTH-1:0];
   assign negative   = signed_mode_ff & value_bits[VALUE_WIDTH-1];
   assign magnitude  = negative ? (~value_bits + {{(VALUE_WIDTH-1){1'b0}}, 1'b1})
                                : value_bits;

   assign signed_mode_in = csr_write_enable ? csr_write_data : signed_mode_ff;

   // Sequencer: load, VALUE_WIDTH dabble steps, leading zero removal, then one digit
   // per cycle from the top of the BCD register. At least one digit is always sent,
   // so zero comes out as a single '0'.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      strobe_in  = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      digit_ctl  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               digit_ctl.load = 1'b1;
               count_in       = CNT_W'(VALUE_WIDTH - 1);
               state_in       = ST_CONVERT;
               if (negative) begin
                  strobe_in = 1'b1;
                  char_in   = CHAR_MINUS;
                  last_in   = 1'b0;
               end
            end
         end
         ST_CONVERT: begin
            digit_ctl.dabble = 1'b1;
            if (count_ff == '0) begin
               remain_in = REM_W'(DIGITS);
               state_in  = ST_SKIP;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && remain_ff > REM_W'(1)) begin
               digit_ctl.drop = 1'b1;
               remain_in      = remain_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            digit_ctl.drop = 1'b1;
            strobe_in      = 1'b1;
            char_in        = CHAR_ZERO + {4'd0, top_digit};
            last_in        = (remain_ff == REM_W'(1));
            remain_in      = remain_ff - 1'b1;
            if (remain_ff == REM_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         strobe_ff      <= 1'b0;
         signed_mode_ff <= 1'b1;
      end else begin
         state_ff       <= state_in;
         strobe_ff      <= strobe_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      remain_ff <= remain_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   i2ad_digits #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_digits (
      .clock     (clock),
      .ctl       (digit_ctl),
      .magnitude (magnitude),
      .top_digit (top_digit)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

   // An accepted transaction keeps the block busy in the following cycle.
   `I2AD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // Every character but the last leaves while the block is still working.
   `I2AD_ASSERT_SAME(a_mid_char_busy, clock, reset, rsp_strobe && !rsp_last_char, busy)
   // The final character closes the transaction: the block is idle while it is shown.
   `I2AD_ASSERT_SAME(a_last_idle, clock, reset, rsp_strobe && rsp_last_char, !busy)
   // Only a minus sign or a decimal digit is ever sent.
   `I2AD_ASSERT_SAME(a_char_legal, clock, reset, rsp_strobe,
      rsp_char_code == CHAR_MINUS || (rsp_char_code >= CHAR_ZERO && rsp_char_code <= CHAR_NINE))

endmodule

// ===== src/i2ad_digits.sv =====
// Binary shift register and BCD digit register with the shared add-3-and-shift unit.
// Depends on i2ad_pkg.
module i2ad_digits
   import i2ad_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 64,
   parameter int unsigned DIGITS      = 20
) (
   input  logic                   clock,
   input  digit_ctl_type          ctl,
   input  logic [VALUE_WIDTH-1:0] magnitude,
   output logic [DIGIT_W-1:0]     top_digit
);

   localparam int unsigned BCD_W = DIGITS * DIGIT_W;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       adjusted;

   // Every digit of five or more gets three added before the left shift.
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adjusted[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adjusted[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctl.load) begin
         bin_in = magnitude;
         bcd_in = '0;
      end else if (ctl.dabble) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {adjusted[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
      end else if (ctl.drop) begin
         bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

endmodule
